// ===== design/tsrl_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrl_pkg
// Shared types, codes and constants of the timestamped sample ring logger.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrl_pkg;

  // Field widths of one stored entry
  localparam int unsigned ID_W    = 16;
  localparam int unsigned TS_W    = 48;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ENTRY_W = ID_W + TS_W + VALUE_W;

  // Input packing: tuser carries the command, tdata timestamp then sample
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IN_DATA_W = 80;

  // Ring depth default and sensor id after reset
  localparam int unsigned DEPTH_DEFAULT   = 16;
  localparam logic [ID_W-1:0] DEV_ID_RESET = 16'd42;

  // Input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_DRAIN = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_EMPTY
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic do_tick;
    logic do_start;
    logic do_stop;
    logic drain_start;
    logic rd_issue;
    logic load_entry;
    logic load_empty;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic rem_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/timestamped_sample_ring_logger_core.sv =====
// ----------------------------------------------------------------------------
// timestamped_sample_ring_logger_core
// Measurement logger: ticks store (sensor id, timestamp, sample) entries in an
// overwriting ring; a drain streams the stored entries oldest first.
//
// Channel   Dir  Signals                    Contents (lowest bit first)
// s_axis    in   tvalid/tready/tdata/tuser  tuser: cmd; tdata: timestamp, sample
// m_axis    out  tvalid/tready/tdata/tlast  tdata: sensor id, timestamp, value;
//                /tuser                     tlast: last; tuser: empty_res
// cfg       in   cfg_wr_en/cfg_wr_data      sensor id register
//
// Tick, start and stop: one can be accepted every cycle while no drain runs.
// A drain holds the input through a RAM read, then a load of the output
// register, per stored entry, or a load of the empty result, plus output stalls.
// Output stalls hold the drain at the output register; input stays blocked.
// Reset (rst, synchronous) clears the flag, pointers, count and output valid;
// the entry RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_sample_ring_logger_core #(
  parameter int unsigned DEPTH = tsrl_pkg::DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [tsrl_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // timestamp, sample
  input  wire logic [tsrl_pkg::CMD_W-1:0]       s_axis_tuser,  // cmd
  // Output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [tsrl_pkg::ENTRY_W-1:0]     m_axis_tdata,  // sensor id, timestamp, value
  output logic                                  m_axis_tlast,  // last
  output logic                                  m_axis_tuser,  // empty_res
  // Sensor id register
  input  wire logic                             cfg_wr_en,
  input  wire logic [tsrl_pkg::ID_W-1:0]        cfg_wr_data
);

  import tsrl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tsrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .status   (status),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  tsrl_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_data     (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_last    (m_axis_tlast),
    .out_empty   (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== design/tsrl_ram.sv =====
// ----------------------------------------------------------------------------
// tsrl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/tsrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsrl_ctrl
// Controller: accepts commands in idle and sequences the drain read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrl_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [tsrl_pkg::CMD_W-1:0]    in_cmd,
  input  wire tsrl_pkg::dp_status_t          status,
  output logic                               in_ready,
  output tsrl_pkg::ctrl_cmd_t                cmd
);

  import tsrl_pkg::*;

  state_t state;
  state_t state_next;
  cmd_t   cmd_code;
  logic   accept;

  assign cmd_code = cmd_t'(in_cmd);
  assign accept   = (state == ST_IDLE) && in_valid;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (cmd_code == CMD_DRAIN)) begin
          state_next = status.count_zero ? ST_EMPTY : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          state_next = status.rem_last ? ST_IDLE : ST_READ;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready        = (state == ST_IDLE);
    cmd.do_tick     = accept && (cmd_code == CMD_TICK);
    cmd.do_start    = accept && (cmd_code == CMD_START);
    cmd.do_stop     = accept && (cmd_code == CMD_STOP);
    cmd.drain_start = accept && (cmd_code == CMD_DRAIN);
    cmd.rd_issue    = (state == ST_READ);
    cmd.load_entry  = (state == ST_LOAD) && status.out_free;
    cmd.load_empty  = (state == ST_EMPTY) && status.out_free;
  end

endmodule

`default_nettype wire

// ===== design/tsrl_dp.sv =====
// ----------------------------------------------------------------------------
// tsrl_dp
// Datapath: sampling flag, ring pointers and fill count, entry RAM, sensor id
// register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrl_dp #(
  parameter int unsigned DEPTH = tsrl_pkg::DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tsrl_pkg::ctrl_cmd_t             cmd,
  output tsrl_pkg::dp_status_t                 status,
  input  wire logic [tsrl_pkg::IN_DATA_W-1:0]  in_data,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tsrl_pkg::ID_W-1:0]       cfg_wr_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [tsrl_pkg::ENTRY_W-1:0]    out_data,
  output logic                                 out_last,
  output logic                                 out_empty
);

  import tsrl_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_MAX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [ID_W-1:0]    dev_id;
  logic               sampling_on;
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [CW-1:0]      count;
  logic [CW-1:0]      rem;
  logic [CW-1:0]      start_sum;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               out_free;

  // Sensor id register
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_id <= DEV_ID_RESET;
    end else if (cfg_wr_en) begin
      dev_id <= cfg_wr_data;
    end
  end

  // Sampling flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_on <= 1'b0;
    end else if (cmd.do_start) begin
      sampling_on <= 1'b1;
    end else if (cmd.do_stop) begin
      sampling_on <= 1'b0;
    end
  end

  // Store an entry on a tick while sampling: value, timestamp, id from high to low
  assign ram_we    = cmd.do_tick && sampling_on;
  assign ram_wdata = {in_data[TS_W +: VALUE_W], in_data[TS_W-1:0], dev_id};

  // Oldest slot: write pointer minus fill count, modulo the ring depth
  assign start_sum = (CW'(wr_ptr) >= count) ? (CW'(wr_ptr) - count)
                                            : (CW'(wr_ptr) + DEPTH_C - count);

  // Write pointer and fill count; count saturates, drain empties the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      count  <= '0;
    end else if (ram_we) begin
      wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      if (count != DEPTH_C) begin
        count <= count + 1'b1;
      end
    end else if (cmd.drain_start) begin
      count <= '0;
    end
  end

  // Read pointer and remaining entries of a drain
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      rem    <= '0;
    end else begin
      if (cmd.drain_start) begin
        rd_ptr <= start_sum[AW-1:0];
        rem    <= count;
      end else if (cmd.rd_issue) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      if (cmd.load_entry) begin
        rem <= rem - 1'b1;
      end
    end
  end

  tsrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // Output register: load when free, drop valid once the transfer is taken
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_entry || cmd.load_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_entry) begin
      out_data  <= ram_rdata;
      out_last  <= (rem == CW'(1));
      out_empty <= 1'b0;
    end else if (cmd.load_empty) begin
      out_data  <= '0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
    end
  end

  // Status to the controller
  assign status.count_zero = (count == '0);
  assign status.rem_last   = (rem == CW'(1));
  assign status.out_free   = out_free;

  // Fill count never passes the ring depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("fill count above ring depth");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_entry || cmd.load_empty) |-> (!out_valid || out_ready))
    else $error("output register loaded while a result is pending");

  // A drain leaves the ring empty
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_start |=> (count == '0))
    else $error("ring not empty after drain start");

  // Entries are only read out while some remain
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_issue || cmd.load_entry) |-> (rem != '0))
    else $error("read-out with no entries remaining");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timestamped sample ring logger. A scoreboard
// mirrors the ring (sensor id, timestamp, sample per slot) and queues the
// entries that each drain must return. Directed tests cover empty drains,
// ignored ticks, field extremes and ring overwrite under output back-pressure;
// randomized sessions then run with varying source gaps and sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsrl_pkg::*;

  localparam int unsigned RING_DEPTH = DEPTH_DEFAULT;
  localparam int unsigned SLOT_W     = $clog2(RING_DEPTH);

  // One drained entry as seen on the output stream
  typedef struct {
    logic [ID_W-1:0]    sid;
    logic [TS_W-1:0]    stamp;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               empty;
  } entry_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;   // timestamp, sample
  logic [CMD_W-1:0]     s_axis_tuser;   // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [ENTRY_W-1:0]   m_axis_tdata;   // sensor id, timestamp, value
  logic                 m_axis_tlast;   // last
  logic                 m_axis_tuser;   // empty_res
  logic                 cfg_wr_en;
  logic [ID_W-1:0]      cfg_wr_data;

  // Scoreboard copy of the logger state
  logic [ID_W-1:0]      cur_dev_id;
  logic [ID_W-1:0]      slot_id    [RING_DEPTH];
  logic [TS_W-1:0]      slot_stamp [RING_DEPTH];
  logic [VALUE_W-1:0]   slot_value [RING_DEPTH];
  int unsigned          wr_slot;
  int unsigned          fill;
  bit                   sampling_on;
  entry_t               pending_entries[$];

  int mismatch_count = 0;
  int applied_items  = 0;
  int src_idle_pct   = 0;
  int snk_stall_pct  = 0;
  int rx_hold_req    = 0;
  int rx_hold_left   = 0;

  timestamped_sample_ring_logger_core #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #2_000_000;
    $display("timestamped_sample_ring_logger_core test failed");
    $finish;
  end

  // Update the ring copy for one accepted transfer; queue drain output
  task automatic ring_apply(cmd_t cmd, logic [TS_W-1:0] stamp, logic [VALUE_W-1:0] value);
    entry_t      ent;
    int unsigned rd;
    case (cmd)
      CMD_START: begin
        sampling_on = 1'b1;
      end
      CMD_STOP: begin
        sampling_on = 1'b0;
      end
      CMD_TICK: begin
        if (sampling_on) begin
          slot_id[SLOT_W'(wr_slot)]    = cur_dev_id;
          slot_stamp[SLOT_W'(wr_slot)] = stamp;
          slot_value[SLOT_W'(wr_slot)] = value;
          if (fill < RING_DEPTH) fill++;
          wr_slot = (wr_slot + 1) % RING_DEPTH;
        end
      end
      default: begin
        if (fill == 0) begin
          ent = '{sid: '0, stamp: '0, value: '0, last: 1'b1, empty: 1'b1};
          pending_entries.push_back(ent);
        end else begin
          rd = (wr_slot + RING_DEPTH - fill) % RING_DEPTH;
          for (int unsigned k = 0; k < fill; k++) begin
            ent.sid   = slot_id[SLOT_W'(rd)];
            ent.stamp = slot_stamp[SLOT_W'(rd)];
            ent.value = slot_value[SLOT_W'(rd)];
            ent.last  = (k + 1 == fill);
            ent.empty = 1'b0;
            pending_entries.push_back(ent);
            rd = (rd + 1) % RING_DEPTH;
          end
          fill = 0;
        end
      end
    endcase
  endtask

  // Offer one item, hold it until the transfer, then drop valid
  task automatic send_item(cmd_t cmd, logic [TS_W-1:0] stamp, logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {value, stamp};
    do @(posedge clk); while (!s_axis_tready);
    if (!(cmd == CMD_TICK && !sampling_on)) applied_items++;
    ring_apply(cmd, stamp, value);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // Hold the source until every queued entry has come out
  task automatic wait_all_results();
    while (pending_entries.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_dev_id(logic [ID_W-1:0] id);
    wait_all_results();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = id;
    @(negedge clk);
    cfg_wr_en  = 1'b0;
    cur_dev_id = id;
  endtask

  function automatic logic [TS_W-1:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return r[TS_W-1:0];
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_dev_id();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return ID_W'($urandom);
    endcase
  endfunction

  // Drain with nothing stored, ticks and stop while sampling is off
  task automatic test_empty_ring();
    send_item(CMD_DRAIN, '0, '0);
    send_item(CMD_TICK, '1, '1);
    send_item(CMD_STOP, '0, '0);
    send_item(CMD_DRAIN, '1, '1);
  endtask

  // Field extremes, repeated start, id change between ticks
  task automatic test_field_extremes();
    write_dev_id('1);
    send_item(CMD_START, '0, '0);
    send_item(CMD_START, '1, '1);
    send_item(CMD_TICK, '0, 32'h7fff_ffff);
    send_item(CMD_TICK, '1, 32'h8000_0000);
    write_dev_id('0);
    send_item(CMD_TICK, 48'haaaa_aaaa_aaaa, 32'hffff_ffff);
    send_item(CMD_TICK, 48'h5555_5555_5555, 32'h0000_0000);
    send_item(CMD_DRAIN, '0, '0);
    send_item(CMD_STOP, '0, '0);
    send_item(CMD_TICK, 48'h1234, 32'h5678);
    send_item(CMD_DRAIN, '0, '0);
  endtask

  // Overwrite a full ring, then keep offering while the sink holds off
  task automatic test_overwrite_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_dev_id(pick_dev_id());
    rx_hold_req = 400;
    send_item(CMD_START, '0, '0);
    repeat (RING_DEPTH + 4) send_item(CMD_TICK, rand_stamp(), rand_value());
    send_item(CMD_DRAIN, '0, '0);
    repeat (5) send_item(CMD_TICK, rand_stamp(), rand_value());
    send_item(CMD_DRAIN, '0, '0);
    send_item(CMD_STOP, '0, '0);
    wait_all_results();
    send_item(CMD_START, '0, '0);
    repeat (3) send_item(CMD_TICK, rand_stamp(), rand_value());
    send_item(CMD_DRAIN, '0, '0);
  endtask

  // Mostly start/ticks/drain sessions, with some random commands mixed in
  task automatic test_random_traffic(int src_pct, int snk_pct, int quota);
    int target;
    int n;
    write_dev_id(pick_dev_id());
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    target = applied_items + quota;
    while (applied_items < target) begin
      if ($urandom_range(9) < 8) begin
        send_item(CMD_START, rand_stamp(), rand_value());
        if ($urandom_range(3) == 0) n = $urandom_range(RING_DEPTH + 1, RING_DEPTH + 8);
        else n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(15) == 0) begin
            send_item($urandom_range(1) ? CMD_STOP : CMD_START, rand_stamp(), rand_value());
          end
          send_item(CMD_TICK, rand_stamp(), rand_value());
        end
        send_item(CMD_DRAIN, rand_stamp(), rand_value());
      end else begin
        send_item(cmd_t'($urandom_range(3)), rand_stamp(), rand_value());
      end
    end
    wait_all_results();
  endtask

  // Sink ready: long hold-off on request, otherwise random stalls
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each output transfer against the oldest queued entry
  always @(posedge clk) begin : check_results
    entry_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual tdata %h tlast %b tuser %b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_entries.pop_front();
        check_field("sensor id", 64'(want.sid), 64'(m_axis_tdata[ID_W-1:0]));
        check_field("timestamp", 64'(want.stamp), 64'(m_axis_tdata[ID_W +: TS_W]));
        check_field("value", 64'(want.value), 64'(m_axis_tdata[ID_W+TS_W +: VALUE_W]));
        check_field("last", 64'(want.last), 64'(m_axis_tlast));
        check_field("empty", 64'(want.empty), 64'(m_axis_tuser));
      end
    end
  end

  initial begin
    int spin;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    cur_dev_id    = DEV_ID_RESET;
    wr_slot       = 0;
    fill          = 0;
    sampling_on   = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_empty_ring();
    test_field_extremes();
    test_overwrite_backpressure();
    test_random_traffic(0, 0, 35);
    test_random_traffic(64, 0, 35);
    test_random_traffic(0, 64, 35);
    test_random_traffic(32, 32, 35);

    for (spin = 0; spin < 100000 && pending_entries.size() != 0; spin++) @(negedge clk);
    repeat (16) @(negedge clk);
    if (pending_entries.size() != 0) begin
      $display("%0t: missing output, expected %0d more entries, actual none",
               $time, pending_entries.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("timestamped_sample_ring_logger_core test passed");
    end else begin
      $display("timestamped_sample_ring_logger_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/tsrl_pkg.sv
design/tsrl_ram.sv
design/tsrl_ctrl.sv
design/tsrl_dp.sv
design/timestamped_sample_ring_logger_core.sv
tb/tb_top.sv
